FILE: sv/tcmb_pkg.sv
// Package for the terrain cell mesh builder: beat payload types, stage structs,
// fixed-point widths and the texture coordinate function.
// Depends on nothing; every other file imports it.
package tcmb_pkg;

  localparam int CoordW    = 24;
  localparam int ElevW     = 16;
  localparam int IdxW      = 7;
  localparam int AbsW      = 16;
  localparam int SqW       = 32;
  localparam int DenW      = 33;
  localparam int DivSteps  = 30;
  localparam int DivQuoW   = DivSteps + 1;
  localparam int SqrtSteps = 16;
  localparam int RootW     = 16;
  localparam int RemW      = 18;
  localparam int TexW      = 15;
  localparam int NormW     = 16;
  localparam int Lanes     = 3;
  localparam int LaneX     = 0;
  localparam int LaneY     = 1;
  localparam int LaneZ     = 2;

  // round(n * 16384 / 99) as floor((n * 16384 + 49) * ceil(2^28 / 99) / 2^28).
  localparam logic [21:0] TexRecip = 22'd2711470;
  localparam logic [21:0] TexHalf  = 22'd49;
  localparam int          TexShift = 28;

  localparam logic [2:0] AddrNorth = 3'd0;
  localparam logic [2:0] AddrEast  = 3'd4;

  typedef struct packed {
    logic [IdxW-1:0]         cell_row;
    logic [IdxW-1:0]         cell_col;
    logic signed [ElevW-1:0] elev_a;
    logic signed [ElevW-1:0] elev_b;
    logic signed [ElevW-1:0] elev_c;
    logic signed [ElevW-1:0] elev_d;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] corner_east;
    logic signed [CoordW-1:0] corner_north;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic [TexW-1:0]          tex_u_near;
    logic [TexW-1:0]          tex_v_near;
    logic [TexW-1:0]          tex_u_far;
    logic [TexW-1:0]          tex_v_far;
    logic signed [ElevW-1:0]  far_elevation;
  } out_t;

  // Fields that ride alongside the normal datapath.
  typedef struct packed {
    logic [CoordW-1:0] corner_east;
    logic [CoordW-1:0] corner_north;
    logic [TexW-1:0]   tex_u_near;
    logic [TexW-1:0]   tex_v_near;
    logic [TexW-1:0]   tex_u_far;
    logic [TexW-1:0]   tex_v_far;
    logic [ElevW-1:0]  far_elevation;
    logic              neg_x;
    logic              neg_z;
  } side_t;

  // Divider lane start: integer quotient bit, remainder and divisor.
  typedef struct packed {
    logic            qi;
    logic [DenW-1:0] rem;
    logic [DenW-1:0] den;
  } lane_t;

  typedef struct packed {
    logic [CoordW-1:0] origin_north;
    logic [CoordW-1:0] origin_east;
  } origin_t;

  function automatic logic [TexW-1:0] tex_q14(input logic [7:0] n);
    logic [21:0] x;
    logic [43:0] p;
    x = {n, 14'b0} + TexHalf;
    p = 44'(x) * 44'(TexRecip);
    return p[TexShift +: TexW];
  endfunction

endpackage

FILE: sv/tcmb_cfg.sv
// APB-style register file holding the grid origin.
// Depends on tcmb_pkg for widths, addresses and the origin struct.
module tcmb_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcmb_pkg::origin_t origin
);
  import tcmb_pkg::*;

  logic [CoordW-1:0] north_r;
  logic [CoordW-1:0] east_r;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Low address bits are ignored; bit 2 picks the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r <= '0;
      east_r  <= '0;
    end else if (wr) begin
      if (paddr[2] == AddrEast[2]) begin
        east_r <= pwdata[CoordW-1:0];
      end else begin
        north_r <= pwdata[CoordW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == AddrEast[2]) begin
      prdata = {{(32-CoordW){1'b0}}, east_r};
    end else begin
      prdata = {{(32-CoordW){1'b0}}, north_r};
    end
  end

  assign origin.origin_north = north_r;
  assign origin.origin_east  = east_r;

endmodule

FILE: sv/tcmb_front.sv
// Front end: elevation differences, squares, squared length and the first
// quotient bit of each normal lane; also builds the side fields. Four stages.
// Depends on tcmb_pkg.
module tcmb_front (
  input  logic              clk,
  input  logic              en,
  input  tcmb_pkg::in_t     in_data,
  input  tcmb_pkg::origin_t origin,
  output tcmb_pkg::side_t   side,
  output tcmb_pkg::lane_t   lane [tcmb_pkg::Lanes]
);
  import tcmb_pkg::*;

  logic [AbsW-1:0] adx_r, adz_r;
  side_t           side_r, side_nxt;
  logic [SqW-1:0]  sqx_r, sqz_r, sqx2_r, sqz2_r;
  logic [DenW-1:0] den_r;
  lane_t           lane_r [Lanes];
  logic signed [ElevW:0] dx, dz;
  logic [DenW-1:0] a2 [Lanes];

  always_comb begin
    dx = 17'(in_data.elev_b) - 17'(in_data.elev_a);
    dz = 17'(in_data.elev_c) - 17'(in_data.elev_a);
    side_nxt.corner_east  = origin.origin_east  + {{(CoordW-IdxW){1'b0}}, in_data.cell_col};
    side_nxt.corner_north = origin.origin_north + {{(CoordW-IdxW){1'b0}}, in_data.cell_row};
    side_nxt.tex_u_near   = tex_q14({1'b0, in_data.cell_row});
    side_nxt.tex_v_near   = tex_q14({1'b0, in_data.cell_col});
    side_nxt.tex_u_far    = tex_q14({1'b0, in_data.cell_row} + 8'd1);
    side_nxt.tex_v_far    = tex_q14({1'b0, in_data.cell_col} + 8'd1);
    side_nxt.far_elevation = in_data.elev_d;
    side_nxt.neg_x        = dx[ElevW];
    side_nxt.neg_z        = dz[ElevW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r  <= dx[ElevW] ? AbsW'(-dx) : AbsW'(dx);
      adz_r  <= dz[ElevW] ? AbsW'(-dz) : AbsW'(dz);
      side_r <= side_nxt;
      sqx_r  <= adx_r * adx_r;
      sqz_r  <= adz_r * adz_r;
      den_r  <= DenW'(sqx_r) + DenW'(sqz_r) + DenW'(1);
      sqx2_r <= sqx_r;
      sqz2_r <= sqz_r;
    end
  end

  assign a2[LaneX] = DenW'(sqx2_r);
  assign a2[LaneY] = DenW'(1);
  assign a2[LaneZ] = DenW'(sqz2_r);

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic hit;
    assign hit = a2[l] >= den_r;
    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[l].qi  <= hit;
        lane_r[l].rem <= hit ? a2[l] - den_r : a2[l];
        lane_r[l].den <= den_r;
      end
    end
    assign lane[l] = lane_r[l];
  end

  assign side = side_r;

endmodule

FILE: sv/tcmb_div_lane.sv
// Pipelined restoring divider: fraction bits of a^2 * 2^30 / S, one bit per stage.
// Depends on tcmb_pkg.
module tcmb_div_lane (
  input  logic                           clk,
  input  logic                           en,
  input  tcmb_pkg::lane_t                lane_in,
  output logic [tcmb_pkg::DivQuoW-1:0]   quo
);
  import tcmb_pkg::*;

  logic [DenW-1:0]    rem_r [DivSteps];
  logic [DenW-1:0]    den_r [DivSteps];
  logic [DivQuoW-1:0] quo_r [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [DenW-1:0]    rem_prev, den_prev;
    logic [DivQuoW-1:0] quo_prev;
    logic [DenW:0]      dbl, diff;
    logic               hit;
    logic [DenW-1:0]    rem_nxt;

    if (k == 0) begin : g_first
      assign rem_prev = lane_in.rem;
      assign den_prev = lane_in.den;
      assign quo_prev = {{(DivQuoW-1){1'b0}}, lane_in.qi};
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign den_prev = den_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    always_comb begin
      dbl     = {rem_prev, 1'b0};
      diff    = dbl - {1'b0, den_prev};
      hit     = dbl >= {1'b0, den_prev};
      rem_nxt = hit ? diff[DenW-1:0] : dbl[DenW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_prev;
        quo_r[k] <= {quo_prev[DivQuoW-2:0], hit};
      end
    end
  end

  assign quo = quo_r[DivSteps-1];

endmodule

FILE: sv/tcmb_sqrt_lane.sv
// Pipelined digit-by-digit integer square root, two radicand bits per stage.
// Depends on tcmb_pkg.
module tcmb_sqrt_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tcmb_pkg::DivQuoW-1:0]  rad_in,
  output logic [tcmb_pkg::RootW-1:0]    root
);
  import tcmb_pkg::*;

  logic [2*SqrtSteps-1:0] rad_r  [SqrtSteps];
  logic [RemW-1:0]        rem_r  [SqrtSteps];
  logic [RootW-1:0]       root_r [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    localparam int Pos = 2 * (SqrtSteps - 1 - k);
    logic [2*SqrtSteps-1:0] rad_prev;
    logic [RemW-1:0]        rem_prev;
    logic [RootW-1:0]       root_prev;
    logic [RemW+1:0]        cur, trial, diff;
    logic                   hit;

    if (k == 0) begin : g_first
      assign rad_prev  = (2*SqrtSteps)'(rad_in);
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign rad_prev  = rad_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
    end

    always_comb begin
      cur   = {rem_prev, rad_prev[Pos +: 2]};
      trial = {2'b00, root_prev, 2'b01};
      hit   = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_prev;
        rem_r[k]  <= hit ? diff[RemW-1:0] : cur[RemW-1:0];
        root_r[k] <= {root_prev[RootW-2:0], hit};
      end
    end
  end

  assign root = root_r[SqrtSteps-1];

endmodule

FILE: sv/terrain_cell_mesh_builder.sv
// Terrain cell mesh builder: one grid cell in, one mesh record out per beat.
// From input beat to output valid a beat passes four front stages, 30
// divider stages, 16 square-root stages and the output register.
// Throughput one beat per cycle; the whole pipeline holds while the output
// register waits. Synchronous active-low reset clears valids and the origin.
module terrain_cell_mesh_builder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcmb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tcmb_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import tcmb_pkg::*;

  localparam int Depth = 4 + DivSteps + SqrtSteps;

  origin_t          origin;
  side_t            side0;
  lane_t            lane [Lanes];
  logic [DivQuoW-1:0] quo [Lanes];
  logic [RootW-1:0] root [Lanes];
  logic [RootW-1:0] mag [Lanes];
  side_t            side_r [Depth-1];
  logic [Depth-1:0] vld_r;
  logic             out_valid_r;
  out_t             out_r, out_nxt;
  logic             en;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tcmb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .origin  (origin)
  );

  tcmb_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .origin  (origin),
    .side    (side0),
    .lane    (lane)
  );

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [RootW:0] rsum;
    tcmb_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .lane_in (lane[l]),
      .quo     (quo[l])
    );
    tcmb_sqrt_lane u_sqrt (
      .clk    (clk),
      .en     (en),
      .rad_in (quo[l]),
      .root   (root[l])
    );
    // Largest q with 2q - 1 not above the root.
    assign rsum   = {1'b0, root[l]} + (RootW+1)'(1);
    assign mag[l] = rsum[RootW:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side0;
      for (int k = 1; k < Depth - 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[Depth-2:0], in_valid};
      out_valid_r <= vld_r[Depth-1];
    end
  end

  always_comb begin
    out_nxt.corner_east   = side_r[Depth-2].corner_east;
    out_nxt.corner_north  = side_r[Depth-2].corner_north;
    out_nxt.normal_x      = side_r[Depth-2].neg_x ? -mag[LaneX] : mag[LaneX];
    out_nxt.normal_y      = -mag[LaneY];
    out_nxt.normal_z      = side_r[Depth-2].neg_z ? -mag[LaneZ] : mag[LaneZ];
    out_nxt.tex_u_near    = side_r[Depth-2].tex_u_near;
    out_nxt.tex_v_near    = side_r[Depth-2].tex_v_near;
    out_nxt.tex_u_far     = side_r[Depth-2].tex_u_far;
    out_nxt.tex_v_far     = side_r[Depth-2].tex_v_far;
    out_nxt.far_elevation = side_r[Depth-2].far_elevation;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.normal_x >= -16'sd16384 && out_data.normal_x <= 16'sd16384 &&
                   out_data.normal_z >= -16'sd16384 && out_data.normal_z <= 16'sd16384))
    else $error("normal component outside unit range");
`endif

endmodule
